// File: src/fqa_pkg.sv
`default_nettype none

package fqa_pkg;

    localparam int unsigned IDX_W       = 7;
    localparam int unsigned CNT_W       = 8;
    localparam int unsigned FRAME_W     = 32;

    localparam logic [CNT_W-1:0]   MAX_QUERIES   = 8'd128;
    localparam logic [CNT_W-1:0]   RING_MIN      = 8'd2;
    localparam logic [CNT_W-1:0]   QCOUNT_RESET  = 8'd96;
    localparam logic [FRAME_W-1:0] FRAME_INVALID = '1;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_BEGIN   = 2'd1,
        OP_END     = 2'd2,
        OP_COLLECT = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NO_QUERY  = 2'd1,
        ST_READBACK  = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ALLOC_CHECK,
        S_ALLOC_INC,
        S_ALLOC_WRAP,
        S_USED_INC,
        S_USED_SAT,
        S_BEGIN_CHECK,
        S_REL_LEN,
        S_REL_WRAP,
        S_REL_ADD,
        S_REL_USED,
        S_BEGIN_STAMP,
        S_END,
        S_SCAN,
        S_RESP
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t           op;
        logic [CNT_W-1:0]  a;
        logic [CNT_W-1:0]  b;
    } alu_req_t;

    typedef struct packed {
        logic [CNT_W-1:0]  res;
        logic              borrow;  // a < b on subtract
    } alu_rsp_t;

endpackage

`default_nettype wire

// File: src/fqa_alu.sv
`default_nettype none

module fqa_alu (
    input  wire fqa_pkg::alu_req_t req,
    output fqa_pkg::alu_rsp_t      rsp
);

    logic [fqa_pkg::CNT_W:0] sum;

    always_comb begin
        unique case (req.op)
            fqa_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
            fqa_pkg::ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
            default:          sum = '0;
        endcase
    end

    assign rsp.res    = sum[fqa_pkg::CNT_W-1:0];
    assign rsp.borrow = (req.op == fqa_pkg::ALU_SUB) && sum[fqa_pkg::CNT_W];

endmodule

`default_nettype wire

// File: src/frame_ring_query_allocator_core.sv
// Query ring allocator: one request at a time, one result per request. A small
// sequencer drives one shared 8-bit add/subtract unit through the pointer and
// count updates, one step per cycle. End frame is a single step, a refused
// allocate or begin ends after its check, allocate steps the pointer (wrapping)
// and the used count (saturating), begin frame may release a range (longest
// when it wrapped) before it stamps, and collect scans the frame records one per
// cycle. The result then sits in the output register until taken, and the next
// request is accepted the cycle after that. query_count may be written only while idle.
`default_nettype none

module frame_ring_query_allocator_core #(
    parameter int unsigned FRAME_RECORDS = 3
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         cfg_we,
    input  wire  [7:0]  cfg_wdata,

    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [1:0]  s_opcode,
    input  wire  [31:0] s_frame_id,
    input  wire         s_results_ready,

    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_status,
    output logic [6:0]  m_query_index,
    output logic [31:0] m_frame_number,
    output logic [6:0]  m_range_start,
    output logic [6:0]  m_range_end
);

    localparam int unsigned REC_W = $clog2(FRAME_RECORDS);
    localparam logic [REC_W-1:0] REC_LAST = REC_W'(FRAME_RECORDS - 1);
    localparam int unsigned IW = fqa_pkg::IDX_W;
    localparam int unsigned CW = fqa_pkg::CNT_W;
    localparam int unsigned FW = fqa_pkg::FRAME_W;

    fqa_pkg::state_t state_reg, state_next;

    logic [CW-1:0]    qcount_reg;
    logic [IW-1:0]    alloc_reg;
    logic [IW-1:0]    free_reg;
    logic [CW-1:0]    used_reg;
    logic [REC_W-1:0] active_reg;
    logic [FW-1:0]    nfc_reg;
    logic [REC_W-1:0] rec_reg;
    logic [CW-1:0]    tmp_reg;

    logic [1:0]       op_reg;
    logic [FW-1:0]    fid_reg;
    logic             rdy_reg;

    logic [FW-1:0] rec_frame_reg    [FRAME_RECORDS];
    logic [IW-1:0] rec_start_reg    [FRAME_RECORDS];
    logic [IW-1:0] rec_end_reg      [FRAME_RECORDS];
    logic [FRAME_RECORDS-1:0] rec_rdback_reg;
    logic [FRAME_RECORDS-1:0] rec_release_reg;

    logic        m_valid_reg;
    logic [1:0]  status_reg;
    logic [6:0]  qidx_reg;
    logic [31:0] fnum_reg;
    logic [6:0]  rs_reg;
    logic [6:0]  re_reg;

    fqa_pkg::alu_req_t alu_req;
    fqa_pkg::alu_rsp_t alu_rsp;

    logic [CW-1:0] ring_len;
    logic          ring_full;
    logic          rec_match;
    logic [FW-1:0] nfc_inc;
    logic          accept;

    fqa_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    always_comb begin
        priority if (qcount_reg < fqa_pkg::RING_MIN) begin
            ring_len = fqa_pkg::RING_MIN;
        end else if (qcount_reg > fqa_pkg::MAX_QUERIES) begin
            ring_len = fqa_pkg::MAX_QUERIES;
        end else begin
            ring_len = qcount_reg;
        end
    end

    assign ring_full = (alloc_reg == free_reg) && (used_reg != '0);
    assign rec_match = (rec_frame_reg[rec_reg] == fid_reg) && rec_rdback_reg[rec_reg];
    assign nfc_inc   = nfc_reg + FW'(1);
    assign accept    = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            fqa_pkg::S_IDLE: begin
                if (s_valid) begin
                    unique case (fqa_pkg::opcode_t'(s_opcode))
                        fqa_pkg::OP_ALLOC:   state_next = fqa_pkg::S_ALLOC_CHECK;
                        fqa_pkg::OP_BEGIN:   state_next = fqa_pkg::S_BEGIN_CHECK;
                        fqa_pkg::OP_END:     state_next = fqa_pkg::S_END;
                        fqa_pkg::OP_COLLECT: state_next = fqa_pkg::S_SCAN;
                        default:             state_next = fqa_pkg::S_IDLE;
                    endcase
                end
            end
            fqa_pkg::S_ALLOC_CHECK:
                state_next = ring_full ? fqa_pkg::S_RESP : fqa_pkg::S_ALLOC_INC;
            fqa_pkg::S_ALLOC_INC:  state_next = fqa_pkg::S_ALLOC_WRAP;
            fqa_pkg::S_ALLOC_WRAP: state_next = fqa_pkg::S_USED_INC;
            fqa_pkg::S_USED_INC:   state_next = fqa_pkg::S_USED_SAT;
            fqa_pkg::S_USED_SAT:   state_next = fqa_pkg::S_RESP;
            fqa_pkg::S_BEGIN_CHECK: begin
                priority if (rec_rdback_reg[rec_reg]) begin
                    state_next = fqa_pkg::S_RESP;
                end else if (rec_release_reg[rec_reg]) begin
                    state_next = fqa_pkg::S_REL_LEN;
                end else begin
                    state_next = fqa_pkg::S_BEGIN_STAMP;
                end
            end
            fqa_pkg::S_REL_LEN:
                state_next = alu_rsp.borrow ? fqa_pkg::S_REL_WRAP : fqa_pkg::S_REL_USED;
            fqa_pkg::S_REL_WRAP:    state_next = fqa_pkg::S_REL_ADD;
            fqa_pkg::S_REL_ADD:     state_next = fqa_pkg::S_REL_USED;
            fqa_pkg::S_REL_USED:    state_next = fqa_pkg::S_BEGIN_STAMP;
            fqa_pkg::S_BEGIN_STAMP: state_next = fqa_pkg::S_RESP;
            fqa_pkg::S_END:         state_next = fqa_pkg::S_RESP;
            fqa_pkg::S_SCAN: begin
                if (rec_match || rec_reg == REC_LAST) begin
                    state_next = fqa_pkg::S_RESP;
                end
            end
            fqa_pkg::S_RESP: begin
                if (m_ready) begin
                    state_next = fqa_pkg::S_IDLE;
                end
            end
            default: state_next = fqa_pkg::S_IDLE;
        endcase
    end

    // shared unit operands and handshake
    always_comb begin
        alu_req.op = fqa_pkg::ALU_ADD;
        alu_req.a  = '0;
        alu_req.b  = '0;
        s_ready    = (state_reg == fqa_pkg::S_IDLE);
        unique case (state_reg)
            fqa_pkg::S_ALLOC_INC: begin
                alu_req.a = {1'b0, alloc_reg};
                alu_req.b = CW'(1);
            end
            fqa_pkg::S_ALLOC_WRAP: begin
                alu_req.op = fqa_pkg::ALU_SUB;
                alu_req.a  = tmp_reg;
                alu_req.b  = ring_len;
            end
            fqa_pkg::S_USED_INC: begin
                alu_req.a = used_reg;
                alu_req.b = CW'(1);
            end
            fqa_pkg::S_USED_SAT: begin
                alu_req.op = fqa_pkg::ALU_SUB;
                alu_req.a  = ring_len;
                alu_req.b  = tmp_reg;
            end
            fqa_pkg::S_REL_LEN: begin
                alu_req.op = fqa_pkg::ALU_SUB;
                alu_req.a  = {1'b0, rec_end_reg[rec_reg]};
                alu_req.b  = {1'b0, rec_start_reg[rec_reg]};
            end
            fqa_pkg::S_REL_WRAP: begin
                alu_req.op = fqa_pkg::ALU_SUB;
                alu_req.a  = ring_len;
                alu_req.b  = {1'b0, rec_start_reg[rec_reg]};
            end
            fqa_pkg::S_REL_ADD: begin
                alu_req.a = tmp_reg;
                alu_req.b = {1'b0, rec_end_reg[rec_reg]};
            end
            fqa_pkg::S_REL_USED: begin
                alu_req.op = fqa_pkg::ALU_SUB;
                alu_req.a  = used_reg;
                alu_req.b  = tmp_reg;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= fqa_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= (state_next == fqa_pkg::S_RESP);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qcount_reg      <= fqa_pkg::QCOUNT_RESET;
            alloc_reg       <= '0;
            free_reg        <= '0;
            used_reg        <= '0;
            active_reg      <= '0;
            nfc_reg         <= '0;
            rec_reg         <= '0;
            rec_rdback_reg  <= '0;
            rec_release_reg <= '0;
            for (int i = 0; i < FRAME_RECORDS; i++) begin
                rec_frame_reg[i] <= fqa_pkg::FRAME_INVALID;
                rec_start_reg[i] <= '0;
                rec_end_reg[i]   <= '0;
            end
        end else begin
            if (cfg_we) begin
                qcount_reg <= cfg_wdata;
            end
            unique case (state_reg)
                fqa_pkg::S_IDLE: begin
                    if (accept) begin
                        rec_reg <= (fqa_pkg::opcode_t'(s_opcode) == fqa_pkg::OP_COLLECT)
                                   ? '0 : active_reg;
                    end
                end
                fqa_pkg::S_ALLOC_WRAP: begin
                    alloc_reg <= alu_rsp.borrow ? tmp_reg[IW-1:0] : '0;
                end
                fqa_pkg::S_USED_SAT: begin
                    used_reg <= alu_rsp.borrow ? ring_len : tmp_reg;
                end
                fqa_pkg::S_REL_USED: begin
                    used_reg                 <= alu_rsp.borrow ? '0 : alu_rsp.res;
                    free_reg                 <= rec_end_reg[rec_reg];
                    rec_release_reg[rec_reg] <= 1'b0;
                end
                fqa_pkg::S_BEGIN_STAMP: begin
                    rec_frame_reg[rec_reg] <= nfc_reg;
                    rec_start_reg[rec_reg] <= alloc_reg;
                    // all ones is reserved as the invalid frame number
                    nfc_reg <= (nfc_inc == fqa_pkg::FRAME_INVALID) ? '0 : nfc_inc;
                end
                fqa_pkg::S_END: begin
                    rec_rdback_reg[rec_reg] <= 1'b1;
                    rec_end_reg[rec_reg]    <= alloc_reg;
                    active_reg <= (rec_reg == REC_LAST) ? '0 : rec_reg + REC_W'(1);
                end
                fqa_pkg::S_SCAN: begin
                    if (rec_match && rdy_reg) begin
                        rec_rdback_reg[rec_reg]  <= 1'b0;
                        rec_release_reg[rec_reg] <= 1'b1;
                    end else if (!rec_match && rec_reg != REC_LAST) begin
                        rec_reg <= rec_reg + REC_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // request latch, scratch and result registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            fqa_pkg::S_IDLE: begin
                if (accept) begin
                    op_reg     <= s_opcode;
                    fid_reg    <= s_frame_id;
                    rdy_reg    <= s_results_ready;
                    status_reg <= (fqa_pkg::opcode_t'(s_opcode) == fqa_pkg::OP_COLLECT)
                                  ? fqa_pkg::ST_NOT_FOUND : fqa_pkg::ST_OK;
                    qidx_reg   <= '0;
                    fnum_reg   <= '0;
                    rs_reg     <= '0;
                    re_reg     <= '0;
                end
            end
            fqa_pkg::S_ALLOC_CHECK: begin
                if (ring_full) begin
                    status_reg <= fqa_pkg::ST_NO_QUERY;
                end else begin
                    qidx_reg <= alloc_reg;
                end
            end
            fqa_pkg::S_ALLOC_INC, fqa_pkg::S_USED_INC, fqa_pkg::S_REL_ADD: begin
                tmp_reg <= alu_rsp.res;
            end
            fqa_pkg::S_REL_LEN: begin
                if (!alu_rsp.borrow) begin
                    tmp_reg <= alu_rsp.res;
                end
            end
            fqa_pkg::S_REL_WRAP: begin
                tmp_reg <= alu_rsp.borrow ? '0 : alu_rsp.res;
            end
            fqa_pkg::S_BEGIN_CHECK: begin
                if (rec_rdback_reg[rec_reg]) begin
                    status_reg <= fqa_pkg::ST_READBACK;
                    fnum_reg   <= fqa_pkg::FRAME_INVALID;
                end
            end
            fqa_pkg::S_REL_USED: begin
                rs_reg <= rec_start_reg[rec_reg];
                re_reg <= rec_end_reg[rec_reg];
            end
            fqa_pkg::S_BEGIN_STAMP: begin
                fnum_reg <= nfc_reg;
            end
            fqa_pkg::S_SCAN: begin
                if (rec_match && rdy_reg) begin
                    status_reg <= fqa_pkg::ST_OK;
                    rs_reg     <= rec_start_reg[rec_reg];
                    re_reg     <= rec_end_reg[rec_reg];
                end
            end
            default: begin
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_query_index  = qidx_reg;
    assign m_frame_number = fnum_reg;
    assign m_range_start  = rs_reg;
    assign m_range_end    = re_reg;

    // op_reg is kept for debug visibility of the request in flight
    logic op_is_collect;
    assign op_is_collect = (fqa_pkg::opcode_t'(op_reg) == fqa_pkg::OP_COLLECT);

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready right after accepting a request");

    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= fqa_pkg::MAX_QUERIES)
        else $error("used count beyond ring capacity");

    a_active_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg <= REC_LAST)
        else $error("active record out of range");

    a_scan_only_collect: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fqa_pkg::S_SCAN) |-> op_is_collect)
        else $error("record scan outside of a collect request");

endmodule

`default_nettype wire
